// ----- hw/rtl/dxt_pkg.sv -----
// Package with the item types, format codes, register indexes and endpoint tables.
`default_nettype none

package dxt_pkg;

  // Block formats held in the format register.
  typedef enum logic [1:0] {
    FMT_DXT1     = 2'd0,
    FMT_DXT3     = 2'd1,
    FMT_DXT5     = 2'd2,
    FMT_RESERVED = 2'd3
  } fmt_t;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DXT1_OPAQUE  = 2'd1;

  // One compressed block.
  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
  } blk_t;

  // One decoded row of four BGRA texels.
  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] texel_col0;
    logic [31:0] texel_col1;
    logic [31:0] texel_col2;
    logic [31:0] texel_col3;
    logic        last_row;
  } row_t;

  // Endpoint expansion tables, v*255/31 and v*255/63 truncated.
  typedef logic [7:0] lut5_t [32];
  typedef logic [7:0] lut6_t [64];

  function automatic lut5_t build_lut5();
    lut5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic lut6_t build_lut6();
    lut6_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam lut5_t EXP5 = build_lut5();
  localparam lut6_t EXP6 = build_lut6();

  // Reciprocal constants for the small constant divisions.
  localparam logic [23:0] DIV3_MUL = 24'd683;
  localparam logic [23:0] DIV5_MUL = 24'd3277;
  localparam logic [23:0] DIV7_MUL = 24'd4682;

endpackage

`default_nettype wire

// ----- hw/rtl/dxt_block_texture_decoder.sv -----
// Top level of the DXT1/DXT3/DXT5 block decoder: a four-stage pipeline and a row sequencer.
//
// Usage:
//   The blk channel (blk_valid, blk_stall, blk) takes one compressed 4x4 block per item:
//   block_low holds bytes 0..7, block_high bytes 8..15 (unused for DXT1).
//   The row channel (row_valid, row_stall, row) returns four items per block, rows 0 to 3,
//   each with four BGRA texels; last_row marks row 3.
//   The cfg port (cfg_we, cfg_index, cfg_data) writes block_format (index 0) and
//   dxt1_index3_opaque (index 1); write only while no block is in flight.
//   A block taken while block_format is 3 yields no rows.
// Timing:
//   The first row of a block passes stages A, B, C and D and then the output register.
//   Stage D keeps a block until its four rows are out; the row sequencer sends one row per
//   cycle, while the output register is not stalled, from the final stage into the output register.
//   Up to four blocks sit in the stages (three pipeline stages and the sequencer), and
//   the last row of a fifth can still wait in the output register.
// Reset and stall:
//   The synchronous reset empties every stage and the output register and sets both
//   registers to 0. While row_stall is high the output row holds, the pipeline fills up
//   behind it, and blk_stall rises once the first stage cannot move.
`default_nettype none

module dxt_block_texture_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            blk_valid,
  output logic                                 blk_stall,
  input  wire dxt_pkg::blk_t                   blk,
  output logic                                 row_valid,
  input  wire logic                            row_stall,
  output dxt_pkg::row_t                        row,
  input  wire logic                            cfg_we,
  input  wire logic [dxt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dxt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Reciprocal divisions, exact over the value ranges used here.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [23:0] p;
    p = 24'(x) * dxt_pkg::DIV3_MUL;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * dxt_pkg::DIV5_MUL;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * dxt_pkg::DIV7_MUL;
    return p[22:15];
  endfunction

  // Configuration registers.
  dxt_pkg::fmt_t cfg_fmt;
  logic          cfg_opq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_fmt <= dxt_pkg::FMT_DXT1;
      cfg_opq <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dxt_pkg::REG_BLOCK_FORMAT: cfg_fmt <= dxt_pkg::fmt_t'(cfg_data);
        dxt_pkg::REG_DXT1_OPAQUE:  cfg_opq <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage registers.
  logic          a_valid, b_valid, c_valid, d_valid;
  dxt_pkg::fmt_t a_fmt, b_fmt, c_fmt, d_fmt;
  logic          a_opq, b_opq, c_opq;
  logic [63:0]   a_lo, b_lo, c_lo, d_lo;
  logic [63:0]   a_col;
  logic [31:0]   b_cidx, c_cidx, d_cidx;
  logic          b_three, c_three;
  logic          b_amode8, c_amode8;
  logic [7:0]    b_e0 [3];
  logic [7:0]    b_e1 [3];
  logic [7:0]    b_a0, b_a1, c_a0, c_a1;
  logic [9:0]    c_s2 [3];
  logic [9:0]    c_s3 [3];
  logic [8:0]    c_mean [3];
  logic [10:0]   c_w7 [6];
  logic [10:0]   c_w5 [4];
  logic [23:0]   d_pal [4];
  logic [7:0]    d_pal3_a;
  logic [7:0]    d_alut [8];
  logic [1:0]    d_row;

  // Handshake: each stage moves when the one after it has room.
  logic o_load, d_done, d_ready, c_ready, b_ready, a_ready;

  assign o_load    = d_valid && (!row_valid || !row_stall);
  assign d_done    = o_load && (d_row == 2'd3);
  assign d_ready   = !d_valid || d_done;
  assign c_ready   = !c_valid || d_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign blk_stall = !a_ready;

  // Stage A: capture the block with the format in force; a reserved format drops it.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= blk_valid && (cfg_fmt != dxt_pkg::FMT_RESERVED);
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_fmt <= cfg_fmt;
      a_opq <= cfg_opq;
      a_lo  <= blk.block_low;
      a_col <= (cfg_fmt == dxt_pkg::FMT_DXT1) ? blk.block_low : blk.block_high;
    end
  end

  // Stage B: expand the 565 endpoints and sort out the palette modes.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_fmt    <= a_fmt;
      b_opq    <= a_opq;
      b_lo     <= a_lo;
      b_cidx   <= a_col[63:32];
      b_three  <= (a_fmt == dxt_pkg::FMT_DXT1) && (a_col[15:0] <= a_col[31:16]);
      b_e0[0]  <= dxt_pkg::EXP5[a_col[4:0]];
      b_e0[1]  <= dxt_pkg::EXP6[a_col[10:5]];
      b_e0[2]  <= dxt_pkg::EXP5[a_col[15:11]];
      b_e1[0]  <= dxt_pkg::EXP5[a_col[20:16]];
      b_e1[1]  <= dxt_pkg::EXP6[a_col[26:21]];
      b_e1[2]  <= dxt_pkg::EXP5[a_col[31:27]];
      b_a0     <= a_lo[7:0];
      b_a1     <= a_lo[15:8];
      b_amode8 <= a_lo[7:0] > a_lo[15:8];
    end
  end

  // Stage C: weighted sums for the color thirds and the alpha sevenths and fifths.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_fmt    <= b_fmt;
      c_opq    <= b_opq;
      c_lo     <= b_lo;
      c_cidx   <= b_cidx;
      c_three  <= b_three;
      c_amode8 <= b_amode8;
      c_a0     <= b_a0;
      c_a1     <= b_a1;
      for (int i = 0; i < 3; i++) begin
        c_s2[i]   <= {1'b0, b_e0[i], 1'b0} + {2'b00, b_e1[i]};
        c_s3[i]   <= {2'b00, b_e0[i]} + {1'b0, b_e1[i], 1'b0};
        c_mean[i] <= {1'b0, b_e0[i]} + {1'b0, b_e1[i]};
      end
      for (int k = 1; k <= 6; k++) begin
        c_w7[k-1] <= 11'(7 - k) * {3'b000, b_a0} + 11'(k) * {3'b000, b_a1};
      end
      for (int k = 1; k <= 4; k++) begin
        c_w5[k-1] <= 11'(5 - k) * {3'b000, b_a0} + 11'(k) * {3'b000, b_a1};
      end
    end
  end

  // Stage D: divide into the color palette and alpha table; this stage then sends rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      d_row   <= 2'd0;
    end else if (d_ready) begin
      d_valid <= c_valid;
      d_row   <= 2'd0;
    end else if (o_load) begin
      d_row   <= d_row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_fmt    <= c_fmt;
      d_lo     <= c_lo;
      d_cidx   <= c_cidx;
      d_pal3_a <= (c_three && !c_opq) ? 8'h00 : 8'hFF;
      // Endpoints come back from the sums: e0 = s2 - mean, e1 = s3 - mean.
      for (int i = 0; i < 3; i++) begin
        d_pal[0][8*i +: 8] <= 8'(c_s2[i] - {1'b0, c_mean[i]});
        d_pal[1][8*i +: 8] <= 8'(c_s3[i] - {1'b0, c_mean[i]});
        if (c_three) begin
          d_pal[2][8*i +: 8] <= c_mean[i][8:1];
          d_pal[3][8*i +: 8] <= 8'h00;
        end else begin
          d_pal[2][8*i +: 8] <= div3(c_s2[i]);
          d_pal[3][8*i +: 8] <= div3(c_s3[i]);
        end
      end
      d_alut[0] <= c_a0;
      d_alut[1] <= c_a1;
      if (c_amode8) begin
        for (int k = 0; k < 6; k++) begin
          d_alut[k+2] <= div7(c_w7[k]);
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          d_alut[k+2] <= div5(c_w5[k]);
        end
        d_alut[6] <= 8'h00;
        d_alut[7] <= 8'hFF;
      end
    end
  end

  // Texel lookup for the row that stage D sends next.
  logic [31:0] tex [4];

  always_comb begin
    logic [1:0] ci;
    logic [3:0] nib;
    logic [2:0] ai;
    logic [5:0] abase;
    logic [7:0] alpha;
    ci    = 2'd0;
    nib   = 4'd0;
    ai    = 3'd0;
    abase = 6'd0;
    alpha = 8'h00;
    for (int col = 0; col < 4; col++) begin
      ci    = d_cidx[{d_row, 2'(col), 1'b0} +: 2];
      nib   = d_lo[{d_row, 2'(col), 2'b00} +: 4];
      abase = 6'd16 + 6'(d_row) * 6'd12 + 6'(col * 3);
      ai    = d_lo[abase +: 3];
      case (d_fmt)
        dxt_pkg::FMT_DXT3: alpha = {nib, nib};
        dxt_pkg::FMT_DXT5: alpha = d_alut[ai];
        default:           alpha = (ci == 2'd3) ? d_pal3_a : 8'hFF;
      endcase
      tex[col] = {alpha, d_pal[ci]};
    end
  end

  // Output register: holds a row until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (o_load) begin
      row_valid <= 1'b1;
    end else if (!row_stall) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      row.row_index  <= d_row;
      row.texel_col0 <= tex[0];
      row.texel_col1 <= tex[1];
      row.texel_col2 <= tex[2];
      row.texel_col3 <= tex[3];
      row.last_row   <= (d_row == 2'd3);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dxt_checker.sv -----
// Port-level checker for the block decoder and the bind that attaches it.
`default_nettype none

module dxt_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          blk_stall,
  input wire logic          row_valid,
  input wire logic          row_stall,
  input wire dxt_pkg::row_t row
);

  // A stalled row item holds its place and its contents.
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_stall |=> row_valid && $stable(row))
    else $error("row item changed while stalled");

  // The rows of a block leave in order with no gap in the row count.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && (row.row_index != 2'd3)
    |=> row_valid && (row.row_index == $past(row.row_index) + 2'd1))
    else $error("row sequence broken within a block");

  // The last-row flag marks row 3 and nothing else.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (row.last_row == (row.row_index == 2'd3)))
    else $error("last_row does not match row_index");

  // Reset leaves the output empty and the input open.
  a_reset: assert property (@(posedge clk)
    rst |=> !row_valid && !blk_stall)
    else $error("output not empty after reset");

endmodule

bind dxt_block_texture_decoder dxt_checker u_dxt_checker (
  .clk       (clk),
  .rst       (rst),
  .blk_stall (blk_stall),
  .row_valid (row_valid),
  .row_stall (row_stall),
  .row       (row)
);

`default_nettype wire
